@@ sv/key_value_table_with_expiry_assert.svh @@
// ----------------------------------------------------------------------------
// Key/value table assertion macros
// Concurrent assertion wrappers clocked on the table's clock.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_WITH_EXPIRY_ASSERT_SVH
`define KEY_VALUE_TABLE_WITH_EXPIRY_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define KVT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("key value table check failed");

// Check a property on every rising edge, reset included.
`define KVT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("key value table check failed");

`endif

@@ sv/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// Key/value table package
// Sizes, entry layout, operation and sequencer codes shared by the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvt_pkg;

   localparam int TABLE_DEPTH     = 16;
   localparam int KEY_BITS        = 64;
   localparam int VALUE_BITS      = 64;

   localparam int OP_BITS         = 3;
   localparam int KEY_PORT_BITS   = 64;
   localparam int VALUE_PORT_BITS = 64;
   localparam int LIFE_BITS       = 32;
   localparam int EXP_BITS        = 48;
   localparam int TL_BITS         = EXP_BITS + 1;

   localparam int ADDR_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int OPND_BITS  = (KEY_BITS > EXP_BITS) ? KEY_BITS : EXP_BITS;

   localparam logic [EXP_BITS-1:0]       EXP_MAX      = '1;
   localparam logic signed [TL_BITS-1:0] TL_NO_EXPIRY = -1;
   localparam logic signed [TL_BITS-1:0] TL_ABSENT    = -2;

   typedef enum logic [OP_BITS-1:0] {
      OP_SET     = 3'd0,
      OP_SET_TTL = 3'd1,
      OP_GET     = 3'd2,
      OP_DELETE  = 3'd3,
      OP_EXISTS  = 3'd4,
      OP_EXPIRE  = 3'd5,
      OP_TTL     = 3'd6,
      OP_FLUSH   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ALU_EXPIRED,
      ALU_KEY_EQ,
      ALU_ADD_SAT,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PURGE_RD,
      ST_PURGE_CHK,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_EXEC,
      ST_CALC,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [EXP_BITS-1:0]   expiry;
   } entry_type;

   typedef struct packed {
      alu_op_type           op;
      logic [OPND_BITS-1:0] lhs;
      logic [OPND_BITS-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic               flag;
      logic [TL_BITS-1:0] res;
   } alu_rsp_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      entry_type            data;
   } mem_wr_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } mem_rd_type;

endpackage

@@ sv/key_value_table_with_expiry.sv @@
// ----------------------------------------------------------------------------
// Key/value table with expiry
// Compacted table of key, value and expiry entries driven by one sequencer.
// ----------------------------------------------------------------------------
// Raise start while busy is low to hand in a command. busy stays high through
// the single result beat. That beat appears on the rsp_ ports for exactly one
// cycle with rsp_valid high and cannot be held off, so the receiver must take
// it then. Every command first sweeps the n live entries and drops expired
// ones. Every command but a flush then searches for the key, one read and one
// compare per entry probed. A delete closes the gap by moving the entries
// after the hit down. A timed set, an expire of a present key or a ttl query
// on a key with an expiry also passes through the calc step on the shared
// unit. The search and the move together cover at most the m entries left
// after the sweep. After the result beat the block returns to idle, where it
// takes the next start. The command time is set by the single read port of
// the entry store and its registered read, shared with one compare unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_value_table_with_expiry (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [kvt_pkg::OP_BITS-1:0]                req_operation,
   input  logic [kvt_pkg::KEY_PORT_BITS-1:0]          req_lookup_key,
   input  logic [kvt_pkg::VALUE_PORT_BITS-1:0]        req_new_value,
   input  logic signed [kvt_pkg::LIFE_BITS-1:0]       req_lifetime_seconds,
   input  logic [kvt_pkg::EXP_BITS-1:0]               req_now_seconds,
   output logic                                       rsp_valid,
   output logic                                       rsp_status,
   output logic [kvt_pkg::VALUE_PORT_BITS-1:0]        rsp_read_value,
   output logic signed [kvt_pkg::TL_BITS-1:0]         rsp_time_left
);
   import kvt_pkg::*;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic [LIFE_BITS-1:0]    life_ff, life_in;
   logic [EXP_BITS-1:0]     now_ff, now_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [COUNT_BITS-1:0]   scan_ff, scan_in;
   logic [COUNT_BITS-1:0]   fill_ff, fill_in;
   logic                    found_ff, found_in;
   entry_type               hit_ff, hit_in;
   logic                    status_ff, status_in;
   logic [VALUE_BITS-1:0]   rval_ff, rval_in;
   logic [TL_BITS-1:0]      tleft_ff, tleft_in;

   logic [COUNT_BITS-1:0]   scan_next;
   logic                    at_end;
   logic                    shift_end;
   logic                    table_full;
   logic                    ins_en;
   logic [ADDR_BITS-1:0]    ins_addr;

   mem_wr_type              mem_wr;
   mem_rd_type              mem_rd;
   entry_type               rd_entry;
   alu_req_type             alu_req;
   alu_rsp_type             alu_rsp;

   kvt_mem u_mem (
      .clock    (clock),
      .mem_wr   (mem_wr),
      .mem_rd   (mem_rd),
      .rd_entry (rd_entry)
   );

   kvt_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign scan_next  = scan_ff + 1'b1;
   assign at_end     = (scan_ff == count_ff);
   assign shift_end  = (scan_next >= count_ff);
   assign table_full = (count_ff == COUNT_BITS'(TABLE_DEPTH));
   assign ins_en     = found_ff || !table_full;
   assign ins_addr   = found_ff ? scan_ff[ADDR_BITS-1:0] : count_ff[ADDR_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PURGE_RD;
            end
         end
         ST_PURGE_RD: begin
            if (at_end) begin
               state_in = (op_ff == OP_FLUSH) ? ST_RESP : ST_FIND_RD;
            end else begin
               state_in = ST_PURGE_CHK;
            end
         end
         ST_PURGE_CHK: state_in = ST_PURGE_RD;
         ST_FIND_RD: state_in = at_end ? ST_EXEC : ST_FIND_CHK;
         ST_FIND_CHK: state_in = alu_rsp.flag ? ST_EXEC : ST_FIND_RD;
         ST_EXEC: begin
            case (op_ff)
               OP_SET_TTL: state_in = ST_CALC;
               OP_EXPIRE:  state_in = found_ff ? ST_CALC : ST_RESP;
               OP_DELETE:  state_in = found_ff ? ST_SHIFT_RD : ST_RESP;
               OP_TTL: begin
                  state_in = (found_ff && (hit_ff.expiry != '0)) ? ST_CALC : ST_RESP;
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_CALC: state_in = ST_RESP;
         ST_SHIFT_RD: state_in = shift_end ? ST_RESP : ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // shared unit operands
   always_comb begin
      alu_req.op  = ALU_KEY_EQ;
      alu_req.lhs = OPND_BITS'(rd_entry.key);
      alu_req.rhs = OPND_BITS'(key_ff);

      case (state_ff)
         ST_PURGE_CHK: begin
            alu_req.op  = ALU_EXPIRED;
            alu_req.lhs = OPND_BITS'(rd_entry.expiry);
            alu_req.rhs = OPND_BITS'(now_ff);
         end
         ST_CALC: begin
            if (op_ff == OP_TTL) begin
               alu_req.op  = ALU_SUB;
               alu_req.lhs = OPND_BITS'(hit_ff.expiry);
               alu_req.rhs = OPND_BITS'(now_ff);
            end else begin
               alu_req.op  = ALU_ADD_SAT;
               alu_req.lhs = OPND_BITS'(now_ff);
               alu_req.rhs = OPND_BITS'(life_ff);
            end
         end
         default: begin
            alu_req.op = ALU_KEY_EQ;
         end
      endcase
   end

   // store ports, handshake
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);

      mem_rd.en   = 1'b0;
      mem_rd.addr = scan_ff[ADDR_BITS-1:0];

      mem_wr.en          = 1'b0;
      mem_wr.addr        = ins_addr;
      mem_wr.data.key    = key_ff;
      mem_wr.data.value  = value_ff;
      mem_wr.data.expiry = '0;

      case (state_ff)
         ST_PURGE_RD: begin
            mem_rd.en = !at_end;
         end
         ST_PURGE_CHK: begin
            // keep the survivor, packed down to the fill pointer
            mem_wr.en   = !alu_rsp.flag;
            mem_wr.addr = fill_ff[ADDR_BITS-1:0];
            mem_wr.data = rd_entry;
         end
         ST_FIND_RD: begin
            mem_rd.en = !at_end;
         end
         ST_EXEC: begin
            mem_wr.en = (op_ff == OP_SET) && ins_en;
         end
         ST_CALC: begin
            mem_wr.data.expiry = alu_rsp.res[EXP_BITS-1:0];
            if (op_ff == OP_SET_TTL) begin
               mem_wr.en = ins_en;
            end else if (op_ff == OP_EXPIRE) begin
               mem_wr.en         = 1'b1;
               mem_wr.addr       = scan_ff[ADDR_BITS-1:0];
               mem_wr.data.key   = hit_ff.key;
               mem_wr.data.value = hit_ff.value;
            end
         end
         ST_SHIFT_RD: begin
            mem_rd.en   = !shift_end;
            mem_rd.addr = scan_next[ADDR_BITS-1:0];
         end
         ST_SHIFT_WR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = scan_ff[ADDR_BITS-1:0];
            mem_wr.data = rd_entry;
         end
         default: begin
            mem_rd.en = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      life_in   = life_ff;
      now_in    = now_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      fill_in   = fill_ff;
      found_in  = found_ff;
      hit_in    = hit_ff;
      status_in = status_ff;
      rval_in   = rval_ff;
      tleft_in  = tleft_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = op_type'(req_operation);
               key_in    = req_lookup_key[KEY_BITS-1:0];
               value_in  = req_new_value[VALUE_BITS-1:0];
               life_in   = req_lifetime_seconds;
               now_in    = req_now_seconds;
               scan_in   = '0;
               fill_in   = '0;
               found_in  = 1'b0;
               status_in = 1'b0;
               rval_in   = '0;
               tleft_in  = '0;
            end
         end
         ST_PURGE_RD: begin
            if (at_end) begin
               count_in = (op_ff == OP_FLUSH) ? '0 : fill_ff;
               scan_in  = '0;
            end
         end
         ST_PURGE_CHK: begin
            if (!alu_rsp.flag) begin
               fill_in = fill_ff + 1'b1;
            end
            scan_in = scan_next;
         end
         ST_FIND_CHK: begin
            if (alu_rsp.flag) begin
               found_in = 1'b1;
               hit_in   = rd_entry;
            end else begin
               scan_in = scan_next;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_SET: begin
                  if (!found_ff && !table_full) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_GET: begin
                  if (found_ff) begin
                     rval_in = hit_ff.value;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_DELETE, OP_EXISTS, OP_EXPIRE: begin
                  status_in = !found_ff;
               end
               OP_TTL: begin
                  if (!found_ff) begin
                     status_in = 1'b1;
                     tleft_in  = TL_ABSENT;
                  end else if (hit_ff.expiry == '0) begin
                     tleft_in = TL_NO_EXPIRY;
                  end
               end
               default: begin
                  status_in = 1'b0;
               end
            endcase
         end
         ST_CALC: begin
            if (op_ff == OP_TTL) begin
               tleft_in = alu_rsp.res;
            end else if ((op_ff == OP_SET_TTL) && !found_ff && !table_full) begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_SHIFT_RD: begin
            if (shift_end) begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_SHIFT_WR: begin
            scan_in = scan_next;
         end
         default: begin
            scan_in = scan_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      life_ff   <= life_in;
      now_ff    <= now_in;
      scan_ff   <= scan_in;
      fill_ff   <= fill_in;
      found_ff  <= found_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      rval_ff   <= rval_in;
      tleft_ff  <= tleft_in;
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = VALUE_PORT_BITS'(rval_ff);
   assign rsp_time_left  = tleft_ff;

endmodule

@@ sv/kvt_alu.sv @@
// ----------------------------------------------------------------------------
// Key/value table shared compare and add unit
// Expiry test, key compare, saturating expiry sum and time-left difference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvt_alu (
   input  kvt_pkg::alu_req_type alu_req,
   output kvt_pkg::alu_rsp_type alu_rsp
);
   import kvt_pkg::*;

   logic [EXP_BITS-1:0]        lhs_time;
   logic [EXP_BITS-1:0]        rhs_time;
   logic signed [EXP_BITS+1:0] sum;
   logic [TL_BITS-1:0]         diff;

   assign lhs_time = alu_req.lhs[EXP_BITS-1:0];
   assign rhs_time = alu_req.rhs[EXP_BITS-1:0];

   // rhs carries the signed lifetime in its low bits
   assign sum = $signed({2'b00, lhs_time})
              + $signed({{(EXP_BITS + 2 - LIFE_BITS){alu_req.rhs[LIFE_BITS-1]}},
                         alu_req.rhs[LIFE_BITS-1:0]});
   assign diff = {1'b0, lhs_time} - {1'b0, rhs_time};

   always_comb begin
      alu_rsp = '0;
      case (alu_req.op)
         ALU_EXPIRED: begin
            alu_rsp.flag = (lhs_time != '0) && (lhs_time <= rhs_time);
         end
         ALU_KEY_EQ: begin
            alu_rsp.flag = (alu_req.lhs == alu_req.rhs);
         end
         ALU_ADD_SAT: begin
            // clamp to 1 .. max so a short lifetime never reads as no expiry
            if (sum[EXP_BITS+1] || (sum == '0)) begin
               alu_rsp.res = TL_BITS'(1);
            end else if (sum[EXP_BITS]) begin
               alu_rsp.res = {1'b0, EXP_MAX};
            end else begin
               alu_rsp.res = {1'b0, sum[EXP_BITS-1:0]};
            end
         end
         ALU_SUB: begin
            alu_rsp.res = diff;
         end
         default: begin
            alu_rsp = '0;
         end
      endcase
   end

endmodule

@@ sv/kvt_mem.sv @@
// ----------------------------------------------------------------------------
// Key/value table entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvt_mem (
   input  logic                clock,
   input  kvt_pkg::mem_wr_type mem_wr,
   input  kvt_pkg::mem_rd_type mem_rd,
   output kvt_pkg::entry_type  rd_entry
);
   import kvt_pkg::*;

   entry_type entries_ff [TABLE_DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         entries_ff[mem_wr.addr] <= mem_wr.data;
      end
      if (mem_rd.en) begin
         rd_entry_ff <= entries_ff[mem_rd.addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

@@ sv/kvt_checker.sv @@
// ----------------------------------------------------------------------------
// Key/value table port checker
// Watches the command and result ports of the table over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_value_table_with_expiry_assert.svh"

module kvt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic                                 rsp_status,
   input logic [kvt_pkg::VALUE_PORT_BITS-1:0]  rsp_read_value,
   input logic signed [kvt_pkg::TL_BITS-1:0]   rsp_time_left
);

   // a taken command keeps the table busy
   `KVT_ASSERT(a_accept_busy, (start && !busy) |=> busy)
   // the result beat ends the command
   `KVT_ASSERT(a_resp_frees, rsp_valid |=> (!busy && !rsp_valid))
   // only a get returns a value, only a ttl query a time
   `KVT_ASSERT(a_one_payload, (rsp_valid && (rsp_time_left != '0)) |-> (rsp_read_value == '0))
   // a time left that marks an absent key comes with the status flag set
   `KVT_ASSERT(a_absent_status, (rsp_valid && (rsp_time_left == -49'sd2)) |-> rsp_status)
   // no result beat while idle
   `KVT_ASSERT_ALWAYS(a_idle_quiet, (!busy && !reset) |-> !rsp_valid)

endmodule

bind key_value_table_with_expiry kvt_checker u_kvt_checker (.*);
